/* rtl/core/sha256_byte_stream_hasher_macros.svh */
// Assertion macros for the SHA-256 byte stream hasher.
// No dependencies; taken in by the files that carry assertions.
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SBH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sbh assertion failed");

// Next-cycle implication, disabled during reset
`define SBH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sbh assertion failed");

`endif

/* rtl/core/sbh_pkg.sv */
// Package for the SHA-256 byte stream hasher: types, constants, round functions.
// No dependencies.
`default_nettype none
package sbh_pkg;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD
    } t_state;

    typedef struct packed {
        logic shift;     // shift working regs, chain read data enters at the top
        logic round_en;  // perform one compression round
        logic use_mem;   // round word from block buffer, else from schedule
    } t_core_ctl;

    localparam logic [7:0]  PAD_BYTE     = 8'h80;
    localparam logic [5:0]  LEN_POS      = 6'd56;
    localparam logic [63:0] BLOCK_BITS   = 64'd512;

    function automatic logic [31:0] init_value(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage
`default_nettype wire

/* rtl/core/sha256_byte_stream_hasher.sv */
// SHA-256 over a byte stream. A byte transfer is accepted while o_stall is low; each 64-byte
// block is compressed in 9 load steps, 64 rounds and 9 fold steps,
// during which o_stall is high. After an end-of-message item, padding writes one
// byte per cycle, then one or two compressions, then eight digest words.
// After reset an initial pass loads the eight initial hash words into the chain memory.
// Depends on sbh_pkg, sbh_ram, sbh_round and the macros header.
`default_nettype none
`include "sha256_byte_stream_hasher_macros.svh"
module sha256_byte_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_msg_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_end_of_message,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [31:0] o_digest_word,
    output logic      [2:0]  o_word_index,
    output logic             o_last_word
);

    sbh_pkg::t_state    r_state, n_state;
    logic [5:0]         r_cnt, n_cnt;
    logic [5:0]         r_fill, n_fill;
    logic [23:0]        r_word, n_word;
    logic [63:0]        r_total, n_total;
    logic [63:0]        r_len, n_len;
    logic               r_eom, n_eom;
    logic               r_pad_first, n_pad_first;
    logic               r_two_blk, n_two_blk;
    logic               r_padding, n_padding;
    logic               r_final, n_final;
    logic               r_ovalid, n_ovalid;
    logic [31:0]        r_odata, n_odata;
    logic [2:0]         r_oidx, n_oidx;
    logic               r_olast, n_olast;

    sbh_pkg::t_core_ctl ctl;
    logic               byte_en;
    logic [7:0]         byte_val;
    logic               blk_we;
    logic [3:0]         blk_raddr;
    logic [31:0]        blk_rdata;
    logic               chain_we;
    logic [2:0]         chain_waddr;
    logic [31:0]        chain_wdata;
    logic               chain_re;
    logic [31:0]        chain_rdata;
    logic [31:0]        v0;
    logic [31:0]        fold_sum;
    logic [5:0]         fill_next;
    logic [63:0]        len_shift;
    logic               adv;

    sbh_ram #(.WIDTH(32), .DEPTH(16)) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (blk_we),
        .i_waddr (r_fill[5:2]),
        .i_wdata ({r_word, byte_val}),
        .i_re    (1'b1),
        .i_raddr (blk_raddr),
        .o_rdata (blk_rdata)
    );

    sbh_ram #(.WIDTH(32), .DEPTH(8)) u_chain_ram (
        .i_clk   (i_clk),
        .i_we    (chain_we),
        .i_waddr (chain_waddr),
        .i_wdata (chain_wdata),
        .i_re    (chain_re),
        .i_raddr (r_cnt[2:0]),
        .o_rdata (chain_rdata)
    );

    sbh_round u_round (
        .i_clk         (i_clk),
        .i_ctl         (ctl),
        .i_round       (r_cnt),
        .i_chain_rdata (chain_rdata),
        .i_blk_rdata   (blk_rdata),
        .o_v0          (v0)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbh_pkg::ST_INIT;
            r_cnt       <= '0;
            r_fill      <= '0;
            r_total     <= '0;
            r_eom       <= 1'b0;
            r_pad_first <= 1'b0;
            r_two_blk   <= 1'b0;
            r_padding   <= 1'b0;
            r_final     <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_fill      <= n_fill;
            r_total     <= n_total;
            r_eom       <= n_eom;
            r_pad_first <= n_pad_first;
            r_two_blk   <= n_two_blk;
            r_padding   <= n_padding;
            r_final     <= n_final;
            r_ovalid    <= n_ovalid;
        end
        r_word  <= n_word;
        r_len   <= n_len;
        r_odata <= n_odata;
        r_oidx  <= n_oidx;
        r_olast <= n_olast;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_fill      = r_fill;
        n_word      = r_word;
        n_total     = r_total;
        n_len       = r_len;
        n_eom       = r_eom;
        n_pad_first = r_pad_first;
        n_two_blk   = r_two_blk;
        n_padding   = r_padding;
        n_final     = r_final;
        n_odata     = r_odata;
        n_oidx      = r_oidx;
        n_olast     = r_olast;
        ctl         = '0;
        byte_en     = 1'b0;
        byte_val    = '0;
        blk_we      = 1'b0;
        blk_raddr   = r_cnt[3:0] + 4'd1;
        chain_we    = 1'b0;
        chain_waddr = r_cnt[2:0] - 3'd1;
        chain_wdata = '0;
        chain_re    = 1'b0;
        o_stall     = 1'b1;
        fold_sum    = chain_rdata + v0;
        fill_next   = i_has_byte ? r_fill + 6'd1 : r_fill;
        len_shift   = r_len >> {~r_fill[2:0], 3'b000};
        adv         = !r_final || !r_ovalid || !i_stall;
        n_ovalid    = i_stall ? r_ovalid : 1'b0;

        case (r_state)
            sbh_pkg::ST_INIT: begin
                chain_we    = 1'b1;
                chain_waddr = r_cnt[2:0];
                chain_wdata = sbh_pkg::init_value(r_cnt[2:0]);
                n_cnt       = r_cnt + 6'd1;
                if (r_cnt[2:0] == 3'd7) begin
                    n_cnt   = '0;
                    n_state = sbh_pkg::ST_IDLE;
                end
            end
            sbh_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    byte_en  = i_has_byte;
                    byte_val = i_msg_byte;
                    if (i_has_byte && r_fill == 6'd63) begin
                        n_total   = r_total + sbh_pkg::BLOCK_BITS;
                        n_eom     = i_end_of_message;
                        n_padding = 1'b0;
                        n_final   = 1'b0;
                        n_cnt     = '0;
                        n_state   = sbh_pkg::ST_LOAD;
                    end else if (i_end_of_message) begin
                        n_len       = r_total + {55'd0, fill_next, 3'b000};
                        n_pad_first = 1'b1;
                        n_two_blk   = fill_next >= sbh_pkg::LEN_POS;
                        n_padding   = 1'b1;
                        n_state     = sbh_pkg::ST_PAD;
                    end
                end
            end
            sbh_pkg::ST_PAD: begin
                byte_en     = 1'b1;
                n_pad_first = 1'b0;
                if (r_pad_first) begin
                    byte_val = sbh_pkg::PAD_BYTE;
                end else if (r_fill >= sbh_pkg::LEN_POS && !r_two_blk) begin
                    byte_val = len_shift[7:0];
                end
                if (r_fill == 6'd63) begin
                    n_final   = !r_two_blk;
                    n_two_blk = 1'b0;
                    n_cnt     = '0;
                    n_state   = sbh_pkg::ST_LOAD;
                end
            end
            sbh_pkg::ST_LOAD: begin
                chain_re  = !r_cnt[3];
                ctl.shift = r_cnt != '0;
                n_cnt     = r_cnt + 6'd1;
                if (r_cnt[3]) begin
                    blk_raddr = '0;
                    n_cnt     = '0;
                    n_state   = sbh_pkg::ST_ROUND;
                end
            end
            sbh_pkg::ST_ROUND: begin
                ctl.round_en = 1'b1;
                ctl.use_mem  = r_cnt[5:4] == 2'b00;
                n_cnt        = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_cnt   = '0;
                    n_state = sbh_pkg::ST_FOLD;
                end
            end
            sbh_pkg::ST_FOLD: begin
                if (adv) begin
                    chain_re = !r_cnt[3];
                    n_cnt    = r_cnt + 6'd1;
                    if (r_cnt != '0) begin
                        chain_we    = 1'b1;
                        chain_wdata = r_final ? sbh_pkg::init_value(chain_waddr) : fold_sum;
                        ctl.shift   = 1'b1;
                        if (r_final) begin
                            n_ovalid = 1'b1;
                            n_odata  = fold_sum;
                            n_oidx   = chain_waddr;
                            n_olast  = r_cnt[3];
                        end
                    end
                    if (r_cnt[3]) begin
                        n_cnt = '0;
                        if (r_final) begin
                            n_total   = '0;
                            n_final   = 1'b0;
                            n_padding = 1'b0;
                            n_state   = sbh_pkg::ST_IDLE;
                        end else if (r_padding) begin
                            n_state = sbh_pkg::ST_PAD;
                        end else if (r_eom) begin
                            // message ended on a block boundary
                            n_len       = r_total;
                            n_pad_first = 1'b1;
                            n_two_blk   = 1'b0;
                            n_padding   = 1'b1;
                            n_eom       = 1'b0;
                            n_state     = sbh_pkg::ST_PAD;
                        end else begin
                            n_state = sbh_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = sbh_pkg::ST_IDLE;
            end
        endcase

        // shared byte path: pack bytes big-endian, write a word every fourth
        if (byte_en) begin
            n_word = {r_word[15:0], byte_val};
            blk_we = r_fill[1:0] == 2'b11;
            n_fill = r_fill + 6'd1;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_digest_word = r_odata;
    assign o_word_index  = r_oidx;
    assign o_last_word   = r_olast;

    `SBH_ASSERT_NXT(a_round_steps, i_clk, i_rst_n,
        r_state == sbh_pkg::ST_ROUND && r_cnt != 6'd63,
        r_state == sbh_pkg::ST_ROUND && r_cnt == $past(r_cnt) + 6'd1)
    `SBH_ASSERT_IMP(a_last_idx, i_clk, i_rst_n, o_valid && o_last_word, o_word_index == 3'd7)
    `SBH_ASSERT_IMP(a_load_fill, i_clk, i_rst_n, r_state == sbh_pkg::ST_LOAD, r_fill == 6'd0)
    `SBH_ASSERT_IMP(a_no_overrun, i_clk, i_rst_n,
        r_state == sbh_pkg::ST_FOLD && r_final && r_ovalid && i_stall, n_cnt == r_cnt)

endmodule
`default_nettype wire

/* rtl/core/sbh_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module sbh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/core/sbh_round.sv */
// Compression round datapath: working variables and 16-word schedule window.
// Depends on sbh_pkg.
`default_nettype none
module sbh_round (
    input  wire logic              i_clk,
    input  wire sbh_pkg::t_core_ctl i_ctl,
    input  wire logic [5:0]        i_round,
    input  wire logic [31:0]       i_chain_rdata,
    input  wire logic [31:0]       i_blk_rdata,
    output logic      [31:0]       o_v0
);

    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [31:0] w_calc;
    logic [31:0] w_use;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    always_comb begin
        w_calc = sbh_pkg::small_sigma1(r_w[14]) + r_w[9]
               + sbh_pkg::small_sigma0(r_w[1]) + r_w[0];
        w_use  = i_ctl.use_mem ? i_blk_rdata : w_calc;
        ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1     = r_v[7] + sbh_pkg::big_sigma1(r_v[4]) + ch
               + sbh_pkg::round_const(i_round) + w_use;
        t2     = sbh_pkg::big_sigma0(r_v[0]) + maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int k = 0; k < 7; k++) begin
                r_v[k] <= r_v[k+1];
            end
            r_v[7] <= i_chain_rdata;
        end else if (i_ctl.round_en) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (i_ctl.round_en) begin
            for (int k = 0; k < 15; k++) begin
                r_w[k] <= r_w[k+1];
            end
            r_w[15] <= w_use;
        end
    end

    assign o_v0 = r_v[0];

endmodule
`default_nettype wire

/* dv/sha256_byte_stream_hasher_tb.sv */
// Self-checking testbench for the SHA-256 byte stream hasher: directed table then random messages.
// Predicts every digest word with its own SHA-256 model; depends only on the RTL top level.
`default_nettype none
module sha256_byte_stream_hasher_tb;

    typedef struct {
        logic [7:0]  b;
        logic        has;
        logic        eom;
        logic [31:0] w0;    // first digest word when known at a glance, else 0
        logic        known;
    } t_stim_row;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_msg_byte = 8'h00;
    logic        i_has_byte = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        i_stall = 1'b0;
    wire         o_stall;
    wire         o_valid;
    wire  [31:0] o_digest_word;
    wire  [2:0]  o_word_index;
    wire         o_last_word;

    sha256_byte_stream_hasher dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic [31:0] hv [8];
    logic [7:0]  blk [64];
    int unsigned nfill;
    logic [63:0] nbits;
    t_digest_out digest_q [$];
    logic [31:0] known_w0 [$];
    int unsigned n_err = 0, n_words = 0, n_items = 0, n_msgs = 0;
    int unsigned hold_off = 0;
    bit          stall_mode = 0;
    bit          done = 0;
    longint      cyc = 0;

    localparam logic [31:0] K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam logic [31:0] IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
        32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int r = 0; r < 16; r++)
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        for (int r = 16; r < 64; r++)
            w[r] = (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
                 + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
        v = hv;
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[r] + w[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int r = 0; r < 8; r++) hv[r] += v[r];
    endtask

    task automatic hash_accept(logic [7:0] b, logic has, logic eom);
        logic [63:0] len;
        int unsigned p;
        if (has) begin
            blk[nfill] = b;
            nfill++;
            if (nfill == 64) begin
                compress();
                nbits += 64'd512;
                nfill = 0;
            end
        end
        if (!eom) return;
        len = nbits + 64'(nfill) * 8;
        p = nfill;
        blk[p++] = 8'h80;
        if (nfill >= 56) begin
            while (p < 64) blk[p++] = 8'h00;
            compress();
            p = 0;
        end
        while (p < 56) blk[p++] = 8'h00;
        for (int i = 0; i < 8; i++) blk[56+i] = len[63-8*i -: 8];
        compress();
        for (int i = 0; i < 8; i++) digest_q.push_back('{hv[i], 3'(i), i == 7});
        hv = IV;
        nfill = 0;
        nbits = '0;
        n_msgs++;
    endtask

    // one transfer on the input side; predictor runs at acceptance
    task automatic send(logic [7:0] b, logic has, logic eom);
        i_valid <= 1'b1;
        i_msg_byte <= b;
        i_has_byte <= has;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        hash_accept(b, has, eom);
        n_items++;
        if ($urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (digest_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic rand_msg(int unsigned nb);
        for (int unsigned k = 0; k < nb; k++) begin
            if ($urandom_range(0, 15) == 0) send(8'($urandom), 1'b0, 1'b0);
            send(8'($urandom), 1'b1, 1'b0);
        end
        if ($urandom_range(0, 1)) send(8'($urandom), 1'b0, 1'b1);
        else send(8'($urandom), 1'b1, 1'b1);
    endtask

    // receiver stall pattern, with one long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_off != 0) begin
            hold_off <= hold_off - 1;
            i_stall <= 1'b1;
        end else if (stall_mode) begin
            i_stall <= ($urandom_range(0, 2) == 0);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_digest_out e;
        cyc <= cyc + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            n_words++;
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest word %h", $time, o_digest_word);
                n_err++;
            end else begin
                e = digest_q.pop_front();
                if (e.idx == 3'd0 && known_w0.size() != 0) begin
                    if (known_w0[0] !== o_digest_word) begin
                        $display("%0t: known word 0 expected %h actual %h", $time,
                                 known_w0[0], o_digest_word);
                        n_err++;
                    end
                    void'(known_w0.pop_front());
                end
                if (e.word !== o_digest_word || e.idx !== o_word_index
                        || e.last !== o_last_word) begin
                    $display("%0t: expected %h/%0d/%b actual %h/%0d/%b", $time,
                             e.word, e.idx, e.last, o_digest_word, o_word_index,
                             o_last_word);
                    n_err++;
                end
            end
        end
        if (cyc > 400000 && !done) begin
            $display("sha256_byte_stream_hasher_tb: done, errors");
            $finish;
        end
    end

    t_stim_row dir_tab [$];

    initial begin
        hv = IV;
        nfill = 0;
        nbits = '0;
        // empty message, "abc", byte-less idles and extremes
        dir_tab.push_back('{8'hff, 1'b0, 1'b1, 32'he3b0c442, 1'b1});
        dir_tab.push_back('{8'h61, 1'b1, 1'b0, 32'h0, 1'b0});
        dir_tab.push_back('{8'h00, 1'b0, 1'b0, 32'h0, 1'b0});
        dir_tab.push_back('{8'h62, 1'b1, 1'b0, 32'h0, 1'b0});
        dir_tab.push_back('{8'h63, 1'b1, 1'b1, 32'hba7816bf, 1'b1});
        dir_tab.push_back('{8'h00, 1'b1, 1'b1, 32'h0, 1'b0});
        dir_tab.push_back('{8'hff, 1'b1, 1'b0, 32'h0, 1'b0});
        dir_tab.push_back('{8'haa, 1'b0, 1'b0, 32'h0, 1'b0});
        dir_tab.push_back('{8'h55, 1'b0, 1'b1, 32'h0, 1'b0});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_tab[k]) begin
            if (dir_tab[k].known) known_w0.push_back(dir_tab[k].w0);
            send(dir_tab[k].b, dir_tab[k].has, dir_tab[k].eom);
        end
        drain();

        // padding boundary: 63 or 64 bytes, two-block padding or an end on a block edge
        rand_msg(63);
        drain();

        stall_mode = 1;
        hold_off = 600;
        rand_msg(30);
        rand_msg(3);
        drain();
        for (int m = 0; m < 4; m++) begin
            rand_msg($urandom_range(0, 6));
            if ($urandom_range(0, 7) == 0) send(8'($urandom), 1'b0, 1'b0);
        end
        drain();
        stall_mode = 0;
        repeat (200) @(posedge i_clk);
        done = 1;
        $display("run: %0d items accepted, %0d messages hashed, %0d digest words checked",
                 n_items, n_msgs, n_words);
        if (n_err == 0 && digest_q.size() == 0 && known_w0.size() == 0)
            $display("sha256_byte_stream_hasher_tb: done, clean");
        else
            $display("sha256_byte_stream_hasher_tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
